>>> rtl/unicode_transcoder_macros.svh
// Assertion helpers for the RTL
`ifndef UNICODE_TRANSCODER_MACROS_SVH
`define UNICODE_TRANSCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define UT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define UT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/ut_pkg.sv
package ut_pkg;

  localparam logic [1:0] ENC_UTF8  = 2'd0;
  localparam logic [1:0] ENC_UTF16 = 2'd1;
  localparam logic [1:0] ENC_UTF32 = 2'd2;

  localparam logic [0:0] REG_INPUT_ENCODING  = 1'b0;
  localparam logic [0:0] REG_OUTPUT_ENCODING = 1'b1;

  localparam logic [1:0] RESET_INPUT_ENCODING  = ENC_UTF8;
  localparam logic [1:0] RESET_OUTPUT_ENCODING = ENC_UTF16;

  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam logic [31:0] SUPPL_BASE     = 32'h0001_0000;
  localparam logic [7:0]  CONT_BASE      = 8'h80;

  typedef logic [31:0] code_t;
  typedef logic [2:0]  count_t;

  typedef struct packed {
    code_t       code;
    logic        err;
    count_t      len;
    logic [1:0]  enc;
  } run_t;

endpackage

>>> rtl/ut_unit_if.sv
interface ut_unit_if import ut_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t unit_in;

  modport source (output valid, output unit_in, input ready);
  modport sink (input valid, input unit_in, output ready);
endinterface

>>> rtl/ut_result_if.sv
interface ut_result_if import ut_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t unit_out;
  logic  last_unit;
  logic  bad_sequence;

  modport source (output valid, output unit_out, output last_unit, output bad_sequence,
                  input ready);
  modport sink (input valid, input unit_out, input last_unit, input bad_sequence,
                output ready);
endinterface

>>> rtl/unicode_transcoder.sv
// Streaming Unicode transcoder. Takes one code unit per item on din in the
// input encoding (UTF-8 with legacy forms up to 8 bytes, UTF-16, UTF-32) and
// returns the same characters on dout in the output encoding, one code unit per
// item, with last_unit on the final unit of each character and bad_sequence on
// the single all-zero item that reports a broken sequence. A new item is taken
// every cycle while each character produces at most one output unit and dout
// is not held off; a character that produces several units (up to 6 for UTF-8,
// 2 for a UTF-16 surrogate pair) is sent out one unit at a time, and the input
// stalls until its last unit is loaded into dout. The user must change
// encodings through the write port only while idle; the block itself does not
// enforce this. Value 3 on either selector acts as UTF-32.
module unicode_transcoder import ut_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [0:0]        wr_index,
  input  logic [1:0]        wr_data,
  ut_unit_if.sink           din,
  ut_result_if.source       dout
);

`include "unicode_transcoder_macros.svh"

  logic [1:0] enc_in;
  logic [1:0] enc_out;
  code_t      code;
  count_t     pending;

  run_t       run;
  logic       run_valid;
  count_t     run_idx;

  code_t      code_next;
  count_t     pending_next;
  logic       dec_emit;
  logic       dec_err;
  count_t     dec_len;

  logic       accept;
  logic       out_load;
  logic       run_done;

  code_t      unit_val;
  logic       unit_last;

  logic [7:0]  b;
  logic [15:0] w;
  logic [3:0]  ones;
  logic        w_high;
  logic        w_low;
  count_t      pend_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_in  <= RESET_INPUT_ENCODING;
      enc_out <= RESET_OUTPUT_ENCODING;
    end else if (wr_en) begin
      case (wr_index)
        REG_INPUT_ENCODING:  enc_in  <= wr_data;
        REG_OUTPUT_ENCODING: enc_out <= wr_data;
        default: ;
      endcase
    end
  end

  assign b        = din.unit_in[7:0];
  assign w        = din.unit_in[15:0];
  assign w_high   = (w[15:10] == 6'b110110);
  assign w_low    = (w[15:10] == 6'b110111);
  assign pend_dec = pending - 3'd1;

  always_comb begin
    casez (b)
      8'b0???????: ones = 4'd0;
      8'b10??????: ones = 4'd1;
      8'b110?????: ones = 4'd2;
      8'b1110????: ones = 4'd3;
      8'b11110???: ones = 4'd4;
      8'b111110??: ones = 4'd5;
      8'b1111110?: ones = 4'd6;
      8'b11111110: ones = 4'd7;
      default:     ones = 4'd8;
    endcase
  end

  always_comb begin
    code_next    = code;
    pending_next = pending;
    dec_emit     = 1'b0;
    dec_err      = 1'b0;
    case (enc_in)
      ENC_UTF8: begin
        if (pending == 3'd0) begin
          if (!b[7]) begin
            code_next = {24'd0, b};
            dec_emit  = 1'b1;
          end else if (ones == 4'd1) begin
            dec_err = 1'b1;
          end else begin
            code_next    = {24'd0, b & (8'hFF >> ones)};
            pending_next = count_t'(ones - 4'd1);
          end
        end else if (b[7:6] != 2'b10) begin
          dec_err = 1'b1;
        end else begin
          pending_next = pend_dec;
          code_next    = {code[25:0], b[5:0]};
          dec_emit     = (pend_dec == 3'd0);
        end
      end
      ENC_UTF16: begin
        if (pending == 3'd0 && w_low) begin
          dec_err = 1'b1;
        end else if (w_high) begin
          pending_next = 3'd1;
          code_next    = {22'd0, w[9:0]};
        end else if (!w_low) begin
          code_next    = {16'd0, w};
          pending_next = 3'd0;
          dec_emit     = 1'b1;
        end else begin
          pending_next = pend_dec;
          code_next    = {code[21:0], w[9:0]} + SUPPL_BASE;
          dec_emit     = (pend_dec == 3'd0);
        end
      end
      default: begin
        code_next    = din.unit_in;
        pending_next = 3'd0;
        dec_emit     = 1'b1;
      end
    endcase
    if (dec_err) begin
      code_next    = '0;
      pending_next = 3'd0;
    end
  end

  always_comb begin
    case (enc_out)
      ENC_UTF8: begin
        if (code_next < 32'h80)            dec_len = 3'd1;
        else if (code_next < 32'h800)      dec_len = 3'd2;
        else if (code_next < 32'h10000)    dec_len = 3'd3;
        else if (code_next < 32'h200000)   dec_len = 3'd4;
        else if (code_next < 32'h4000000)  dec_len = 3'd5;
        else                               dec_len = 3'd6;
      end
      ENC_UTF16: dec_len = (code_next < SUPPL_BASE) ? 3'd1 : 3'd2;
      default:   dec_len = 3'd1;
    endcase
    if (dec_err) dec_len = 3'd1;
  end

  assign out_load  = !dout.valid || dout.ready;
  assign run_done  = run_valid && out_load && (run_idx == run.len - 3'd1);
  assign din.ready = !run_valid || run_done;
  assign accept    = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      code    <= '0;
      pending <= '0;
    end else if (accept) begin
      code    <= code_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_idx   <= '0;
    end else begin
      if (accept) begin
        run_valid <= dec_emit || dec_err;
        run_idx   <= '0;
      end else begin
        if (run_valid && out_load) begin
          run_idx <= run_idx + 3'd1;
        end
        if (run_done) begin
          run_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run.code <= code_next;
      run.err  <= dec_err;
      run.len  <= dec_len;
      run.enc  <= enc_out;
    end
  end

  logic [2:0]  tail;
  code_t       surr;
  logic [7:0]  lead;
  logic [5:0]  cont;

  assign tail = run.len - 3'd1 - run_idx;
  assign surr = run.code - SUPPL_BASE;

  always_comb begin
    case (run.len)
      3'd2:    lead = 8'hC0 + {3'd0, run.code[10:6]};
      3'd3:    lead = 8'hE0 + {3'd0, run.code[16:12]};
      3'd4:    lead = 8'hF0 + {3'd0, run.code[22:18]};
      3'd5:    lead = 8'hF8 + {3'd0, run.code[28:24]};
      default: lead = 8'hFC + {6'd0, run.code[31:30]};
    endcase
    case (tail)
      3'd0:    cont = run.code[5:0];
      3'd1:    cont = run.code[11:6];
      3'd2:    cont = run.code[17:12];
      3'd3:    cont = run.code[23:18];
      default: cont = run.code[29:24];
    endcase
  end

  always_comb begin
    unit_last = (tail == 3'd0);
    if (run.err) begin
      unit_val = '0;
    end else begin
      case (run.enc)
        ENC_UTF8: begin
          if (run.len == 3'd1)       unit_val = run.code;
          else if (run_idx == 3'd0)  unit_val = {24'd0, lead};
          else                       unit_val = {24'd0, CONT_BASE + {2'd0, cont}};
        end
        ENC_UTF16: begin
          if (run.len == 3'd1)       unit_val = {16'd0, run.code[15:0]};
          else if (run_idx == 3'd0)  unit_val = {16'd0, HIGH_SURR_BASE + surr[25:10]};
          else                       unit_val = {16'd0, LOW_SURR_BASE + {6'd0, surr[9:0]}};
        end
        default: unit_val = run.code;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (out_load) begin
      dout.valid <= run_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && run_valid) begin
      dout.unit_out     <= unit_val;
      dout.last_unit    <= unit_last;
      dout.bad_sequence <= run.err;
    end
  end

  `UT_ASSERT_NOW(a_err_single, dout.valid && dout.bad_sequence, dout.last_unit && dout.unit_out == '0)
  `UT_ASSERT_NOW(a_run_idx_range, run_valid, run_idx < run.len)
  `UT_ASSERT_NEXT(a_err_clears, accept && dec_err, pending == 3'd0 && code == '0)
  `UT_ASSERT_NEXT(a_utf32_no_pending, accept && enc_in != ENC_UTF8 && enc_in != ENC_UTF16, pending == 3'd0)

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ut_pkg::*;

  localparam logic [1:0] ENC_UTF32_ALT = 2'd3;
  localparam logic [1:0] ENC_ORDER [4] = '{ENC_UTF8, ENC_UTF16, ENC_UTF32, ENC_UTF32_ALT};
  localparam int DRAIN_CYCLES    = 12;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int ITEMS_PER_PHASE = 28;
  localparam int PHASES          = 12;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    code_t word;
    logic  last;
    logic  bad;
  } out_unit_t;

  class transcode_board;
    logic [1:0] in_enc;
    logic [1:0] out_enc;
    code_t      code;
    count_t     pending;
    out_unit_t  out_units[$];
    int         checked;
    int         mismatches;
    int         errors_seen;

    function new();
      in_enc      = RESET_INPUT_ENCODING;
      out_enc     = RESET_OUTPUT_ENCODING;
      code        = '0;
      pending     = '0;
      checked     = 0;
      mismatches  = 0;
      errors_seen = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [1:0] val);
      if (idx == REG_INPUT_ENCODING) begin
        in_enc = val;
      end else begin
        out_enc = val;
      end
    endfunction

    function void push(code_t word, logic last, logic bad);
      out_unit_t e;
      e.word = word;
      e.last = last;
      e.bad  = bad;
      out_units.push_back(e);
    endfunction

    function void break_seq();
      code    = '0;
      pending = '0;
      push('0, 1'b1, 1'b1);
    endfunction

    function void emit_char();
      code_t c;
      code_t v;
      code_t lead;
      code_t t;
      int    n;
      c = code;
      case (out_enc)
        ENC_UTF8: begin
          if (c < 32'h80) begin
            push(c, 1'b1, 1'b0);
          end else begin
            if (c < 32'h800) begin
              n = 2; lead = 32'hC0 + ((c >> 6) & 32'h1F);
            end else if (c < 32'h10000) begin
              n = 3; lead = 32'hE0 + ((c >> 12) & 32'h1F);
            end else if (c < 32'h200000) begin
              n = 4; lead = 32'hF0 + ((c >> 18) & 32'h1F);
            end else if (c < 32'h4000000) begin
              n = 5; lead = 32'hF8 + ((c >> 24) & 32'h1F);
            end else begin
              n = 6; lead = 32'hFC + ((c >> 30) & 32'h1F);
            end
            push({24'b0, lead[7:0]}, 1'b0, 1'b0);
            for (int i = n - 2; i >= 0; i--) begin
              push(32'h80 + ((c >> (6 * i)) & 32'h3F), i == 0, 1'b0);
            end
          end
        end
        ENC_UTF16: begin
          if (c < SUPPL_BASE) begin
            push({16'b0, c[15:0]}, 1'b1, 1'b0);
          end else begin
            v = c - SUPPL_BASE;
            t = code_t'(HIGH_SURR_BASE) + (v >> 10);
            push({16'b0, t[15:0]}, 1'b0, 1'b0);
            t = code_t'(LOW_SURR_BASE) + (v & 32'h3FF);
            push({16'b0, t[15:0]}, 1'b1, 1'b0);
          end
        end
        default: begin
          push(c, 1'b1, 1'b0);
        end
      endcase
    endfunction

    function void take_unit(code_t u);
      logic [7:0]  b;
      logic [15:0] w;
      logic        high;
      logic        low;
      int          n;
      case (in_enc)
        ENC_UTF8: begin
          b = u[7:0];
          if (pending == 0) begin
            if (!b[7]) begin
              code = {24'b0, b};
              emit_char();
            end else begin
              n = 0;
              while (n < 8 && b[7 - n]) n++;
              if (n == 1) begin
                break_seq();
              end else begin
                code    = (n >= 8) ? '0 : {24'b0, b & (8'hFF >> n)};
                pending = count_t'(n - 1);
              end
            end
          end else if (b[7:6] != 2'b10) begin
            break_seq();
          end else begin
            pending = pending - 1'b1;
            code    = (code << 6) + {26'b0, b[5:0]};
            if (pending == 0) emit_char();
          end
        end
        ENC_UTF16: begin
          w    = u[15:0];
          high = (w >= HIGH_SURR_BASE) && (w < LOW_SURR_BASE);
          low  = (w >= LOW_SURR_BASE) && (w < 16'hE000);
          if (pending == 0 && low) begin
            break_seq();
          end else if (high) begin
            pending = 3'd1;
            code    = {22'b0, w[9:0]};
          end else if (!low) begin
            code    = {16'b0, w};
            pending = '0;
            emit_char();
          end else begin
            pending = pending - 1'b1;
            code    = (code << 10) + {22'b0, w[9:0]} + SUPPL_BASE;
            if (pending == 0) emit_char();
          end
        end
        default: begin
          code    = u;
          pending = '0;
          emit_char();
        end
      endcase
    endfunction

    function void match_unit(code_t word, logic last, logic bad);
      out_unit_t e;
      if (bad) errors_seen++;
      if (out_units.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected output unit %h last %b bad %b", word, last, bad);
        end
        return;
      end
      e = out_units.pop_front();
      checked++;
      if (e.word !== word || e.last !== last || e.bad !== bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("mismatch: got %h last %b bad %b, expected %h last %b bad %b",
                   word, last, bad, e.word, e.last, e.bad);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [0:0]  wr_index;
  logic [1:0]  wr_data;

  ut_unit_if   din ();
  ut_result_if dout ();

  unicode_transcoder u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .din      (din),
    .dout     (dout)
  );

  transcode_board board;
  int units_sent   = 0;
  int hold_offs    = 0;
  bit src_steady   = 1'b0;
  bit sink_steady  = 1'b0;
  bit hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (din.valid && din.ready) board.take_unit(din.unit_in);
      if (dout.valid && dout.ready) begin
        board.match_unit(dout.unit_out, dout.last_unit, dout.bad_sequence);
      end
    end
  end

  function automatic int pause_len(int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < zero_pct + (100 - zero_pct) * 4 / 5) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  initial begin : result_sink
    int span;
    dout.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        dout.ready <= 1'b0;
        span = 0;
        while (span < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          span++;
        end
        hold_off_req = 1'b0;
        hold_offs++;
      end else if (sink_steady || $urandom_range(0, 99) < 65) begin
        dout.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        dout.ready <= 1'b0;
        repeat (pause_len(0)) @(posedge clk);
      end
    end
  end

  task automatic send_unit(input code_t u);
    int gap;
    din.valid   <= 1'b1;
    din.unit_in <= u;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    units_sent++;
    gap = src_steady ? 0 : pause_len(50);
    if (gap > 0) begin
      din.valid   <= 1'b0;
      din.unit_in <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the input until every expected unit is out, then let the serializer go quiet
  task automatic drain_results();
    din.valid <= 1'b0;
    do @(posedge clk); while (board.out_units.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_utf8_char();
    int         r;
    int         n;
    logic [7:0] lead;
    code_t      u;
    r = $urandom_range(0, 99);
    if (r < 35)      n = 1;
    else if (r < 55) n = 2;
    else if (r < 70) n = 3;
    else if (r < 82) n = 4;
    else if (r < 90) n = 5;
    else if (r < 95) n = 6;
    else if (r < 98) n = 7;
    else             n = 8;
    if (n == 1) lead = 8'($urandom_range(0, 127));
    else        lead = 8'((8'hFF << (8 - n)) | ($urandom() & (8'hFF >> (n + 1))));
    u = $urandom();
    u[7:0] = lead;
    send_unit(u);
    for (int k = 0; k < n - 1; k++) begin
      u = $urandom();
      u[7:6] = 2'b10;
      send_unit(u);
    end
  endtask

  task automatic send_utf16_char();
    int    r;
    code_t u;
    r = $urandom_range(0, 99);
    u = $urandom();
    if (r < 55) begin
      u[15:0] = 16'($urandom_range(0, 16'hF7FF));
      if (u[15:0] >= HIGH_SURR_BASE) u[15:0] = u[15:0] + 16'h0800;
      send_unit(u);
    end else if (r < 85) begin
      u[15:10] = HIGH_SURR_BASE[15:10];
      send_unit(u);
      u = $urandom();
      u[15:10] = LOW_SURR_BASE[15:10];
      send_unit(u);
    end else begin
      send_unit(u);
    end
  endtask

  task automatic send_char(input logic [1:0] enc);
    case (enc)
      ENC_UTF8: begin
        if ($urandom_range(0, 99) < 85) send_utf8_char();
        else send_unit($urandom());
      end
      ENC_UTF16: send_utf16_char();
      default: send_unit($urandom() >> $urandom_range(0, 31));
    endcase
  endtask

  initial begin : stimulus
    int         base;
    int         fails;
    logic [1:0] in_e;
    logic [1:0] out_e;
    board = new();
    rst         <= 1'b1;
    wr_en       <= 1'b0;
    wr_index    <= REG_INPUT_ENCODING;
    wr_data     <= ENC_UTF8;
    din.valid   <= 1'b0;
    din.unit_in <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset encodings: UTF-8 in, UTF-16 out
    send_unit(32'hFFFF_FF41);
    send_unit(32'h80);
    send_unit(32'hF0);
    send_unit(32'h9F);
    send_unit(32'h98);
    send_unit(32'h80);
    send_unit(32'hE2);
    send_unit(32'h41);
    send_unit(32'hF4);
    drain_results();
    // switch to UTF-16 with a UTF-8 lead still pending
    write_reg(REG_INPUT_ENCODING, ENC_UTF16);
    send_unit(32'hDC00);
    send_unit(32'hDFFF);
    send_unit(32'hDC01);
    drain_results();
    write_reg(REG_OUTPUT_ENCODING, ENC_UTF8);
    send_unit(32'hD83D);
    send_unit(32'hDE00);
    send_unit(32'hDC00);
    send_unit(32'hD800);
    send_unit(32'h0041);
    send_unit(32'hDBFF);
    send_unit(32'hD800);
    send_unit(32'hDFFF);
    send_unit(32'hFFFF);
    drain_results();
    write_reg(REG_INPUT_ENCODING, ENC_UTF32_ALT);
    send_unit(32'hFFFF_FFFF);
    send_unit(32'h03FF_FFFF);
    send_unit(32'h0000_0000);
    drain_results();
    write_reg(REG_OUTPUT_ENCODING, ENC_UTF32_ALT);
    send_unit(32'h1234_5678);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      in_e  = ENC_ORDER[p % 4];
      out_e = ENC_ORDER[(p + p / 4) % 4];
      write_reg(REG_INPUT_ENCODING, in_e);
      write_reg(REG_OUTPUT_ENCODING, out_e);
      src_steady   = (p == 7 || p == 8);
      sink_steady  = (p == 8);
      hold_off_req = (p == 7);
      base = units_sent;
      while (units_sent - base < ITEMS_PER_PHASE) send_char(in_e);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    drain_results();

    fails = board.mismatches + board.out_units.size();
    $display("sent %0d input units over %0d encoding settings, checked %0d output units",
             units_sent, PHASES + 5, board.checked);
    $display("%0d error units seen, %0d long receiver hold-offs, %0d mismatches",
             board.errors_seen, hold_offs, board.mismatches);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> unicode_transcoder.f
+incdir+rtl
rtl/ut_pkg.sv
rtl/ut_unit_if.sv
rtl/ut_result_if.sv
rtl/unicode_transcoder.sv
test/testbench.sv
